// ===== hdl/mcb_pkg.sv =====
// Shared types and constants of the masked cross blur block.
// Used by mcb_cell, mcb_lane and masked_cross_blur_2d; depends on nothing.
`timescale 1ns / 1ps

package mcb_pkg;

   localparam int MAX_WIDTH_DEFAULT = 32;
   localparam int CHAN_W            = 8;
   localparam int NB_N              = 4;
   localparam int CSR_IDX_W         = 1;
   localparam int CSR_DATA_W        = 8;
   localparam int ROW_WIDTH_W       = 6;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_AMOUNT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_WIDTH = 1'd1;

   localparam logic [CSR_DATA_W-1:0]  AMOUNT_RESET    = 8'd0;
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 6'd16;

   localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'd255;
   localparam logic [CHAN_W-1:0] FLOOR_LIMIT = 8'd4;

   // one stored pixel
   typedef struct packed {
      logic              present;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pix_type;

   // one column of the three-row window: r0 above, r1 previous row, r2 current row
   typedef struct packed {
      pix_type r0;
      pix_type r1;
      pix_type r2;
   } col_type;

   typedef struct packed {
      logic adv;     // rotate the ring by one column
      logic vshift;  // row end: move every row up by one
   } cell_ctl_type;

   typedef struct packed {
      logic            blend;  // present center and nonzero amount
      logic [NB_N-1:0] nb_en;  // neighbor contributes (left, right, up, down)
   } lane_ctl_type;

endpackage

// ===== hdl/mcb_cell.sv =====
// One column cell of the rotating line store ring.
// Depends on mcb_pkg.
`timescale 1ns / 1ps

module mcb_cell (
   input  logic                  clock,
   input  mcb_pkg::cell_ctl_type ctl,
   input  mcb_pkg::col_type      src,
   output mcb_pkg::col_type      q
);

   mcb_pkg::col_type col_ff;
   mcb_pkg::col_type col_in;

   always_comb begin
      col_in = col_ff;
      if (ctl.adv) begin
         if (ctl.vshift) begin
            col_in.r0 = src.r1;
            col_in.r1 = src.r2;
            col_in.r2 = src.r2;
         end else begin
            col_in = src;
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

   assign q = col_ff;

endmodule

// ===== hdl/mcb_lane.sv =====
// One color channel of the blend datapath: product stage, then sum, scale and clamp.
// Depends on mcb_pkg.
`timescale 1ns / 1ps

module mcb_lane (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic [mcb_pkg::CHAN_W-1:0]              amount,
   input  mcb_pkg::lane_ctl_type                   ctl,
   input  logic [mcb_pkg::CHAN_W-1:0]              center,
   input  logic [mcb_pkg::NB_N-1:0][mcb_pkg::CHAN_W-1:0] nb,
   output logic [mcb_pkg::CHAN_W-1:0]              result
);

   localparam int CW    = mcb_pkg::CHAN_W;
   localparam int SH_W  = CW - 2;
   localparam int PC_W  = 2 * CW;
   localparam int PN_W  = CW + SH_W;
   localparam int SUM_W = PC_W + 1;

   logic [CW-1:0]                       weight_c;
   logic [SH_W-1:0]                     share;
   logic [PC_W-1:0]                     prod_c_ff, prod_c_in;
   logic [mcb_pkg::NB_N-1:0][PN_W-1:0]  prod_n_ff, prod_n_in;
   logic [CW-1:0]                       center_ff;
   logic                                blend_ff;
   logic [SUM_W-1:0]                    sum;
   logic [SUM_W-CW-1:0]                 scaled;
   logic [CW-1:0]                       result_ff, result_in;

   assign weight_c = mcb_pkg::CHAN_MAX - amount;
   assign share    = amount[CW-1:2];

   always_comb begin
      prod_c_in = PC_W'(center) * PC_W'(weight_c);
      for (int k = 0; k < mcb_pkg::NB_N; k++) begin
         prod_n_in[k] = ctl.nb_en[k] ? PN_W'(nb[k]) * PN_W'(share) : '0;
      end
   end

   always_comb begin
      sum = SUM_W'(prod_c_ff);
      for (int k = 0; k < mcb_pkg::NB_N; k++) begin
         sum = sum + SUM_W'(prod_n_ff[k]);
      end
      scaled = sum[SUM_W-1:CW];
      if (!blend_ff) begin
         result_in = center_ff;
      end else if (scaled == '0 && center_ff > mcb_pkg::FLOOR_LIMIT) begin
         result_in = CW'(1);
      end else if (scaled[SUM_W-CW-1]) begin
         result_in = mcb_pkg::CHAN_MAX;
      end else begin
         result_in = scaled[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_c_ff <= prod_c_in;
         prod_n_ff <= prod_n_in;
         center_ff <= center;
         blend_ff  <= ctl.blend;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ===== hdl/masked_cross_blur_2d.sv =====
// Top level of the masked five-point cross blur for LED frames.
// Depends on mcb_pkg, mcb_cell and mcb_lane.
`timescale 1ns / 1ps
//
// Usage:
//  - Pixels arrive in raster order on the req_ channel (valid/ready), one
//    per request, with a present flag and an end-of-frame flag on the last.
//  - Results leave on the rsp_ channel: pixel x of row y-1 comes out for the
//    request at column x of row y; the first row gives no result.
//  - A request flagged end of frame also flushes the rest of the previous
//    row and the current row up to its column; rsp_last_of_run marks the
//    final result of each request.
//  - Throughput: one request per cycle while the receiver keeps up. A
//    request with end of frame holds req_ready low while the ring of column
//    cells rotates once to drain the window.
//  - Pipeline: each result passes the product stage, then the output
//    register.
//  - Line store: a ring of MAX_WIDTH column cells, each holding three rows;
//    cell 0 always holds the current column and the ring rotates by one
//    column per request or flush step.
//  - When the receiver stalls, the whole pipeline holds and req_ready drops.
//  - Reset clears the control state, sets amount to 0 and row width to 16.
//    Only the user keeps csr_ writes to idle; a row width write restarts the frame.

module masked_cross_blur_2d #(
   parameter int MAX_WIDTH = mcb_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mcb_pkg::CHAN_W-1:0]       req_red_in,
   input  logic [mcb_pkg::CHAN_W-1:0]       req_green_in,
   input  logic [mcb_pkg::CHAN_W-1:0]       req_blue_in,
   input  logic                             req_present_in,
   input  logic                             req_end_of_frame,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mcb_pkg::CHAN_W-1:0]       rsp_red_out,
   output logic [mcb_pkg::CHAN_W-1:0]       rsp_green_out,
   output logic [mcb_pkg::CHAN_W-1:0]       rsp_blue_out,
   output logic                             rsp_present_out,
   output logic                             rsp_last_of_run,
   input  logic                             csr_we,
   input  logic [mcb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mcb_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int NEXT_IDX = (MAX_WIDTH > 1) ? 1 : 0;
   localparam int WW_W     = mcb_pkg::ROW_WIDTH_W + 1;
   localparam int W_RST    = (int'(mcb_pkg::ROW_WIDTH_RESET) < MAX_WIDTH) ?
                             int'(mcb_pkg::ROW_WIDTH_RESET) : MAX_WIDTH;
   localparam logic [COL_W-1:0] W_LAST_RST = COL_W'(W_RST - 1);
   localparam int CW = mcb_pkg::CHAN_W;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FLUSH_PREV,
      ST_FLUSH_CUR
   } state_type;

   // control registers
   state_type            state_ff, state_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [1:0]           rows_ff, rows_in;
   logic [COL_W-1:0]     x_end_ff, x_end_in;
   logic [CW-1:0]        amount_ff, amount_in;
   logic [COL_W-1:0]     w_last_ff, w_last_in;
   logic                 p_valid_ff;
   logic                 rsp_valid_ff;

   // payload registers
   mcb_pkg::pix_type     left_ff, left_in;
   logic                 p_present_ff, p_last_ff;
   logic                 rsp_present_ff, rsp_last_ff;

   logic                 en, accept, step, at_last;
   mcb_pkg::pix_type     pix_new;
   mcb_pkg::col_type     c0, c1, c0_mod;
   mcb_pkg::col_type     cells_q [MAX_WIDTH];
   mcb_pkg::cell_ctl_type cell_ctl;

   logic                 job_valid, job_last;
   mcb_pkg::pix_type     center, right_pix, up_pix;
   logic                 left_ok, right_ok, up_ok, down_ok;
   mcb_pkg::lane_ctl_type lane_ctl;
   logic [mcb_pkg::NB_N-1:0][CW-1:0] nb_red, nb_green, nb_blue;
   mcb_pkg::pix_type     nb_pix [mcb_pkg::NB_N];

   logic [WW_W-1:0]      wr_width;
   logic [COL_W-1:0]     w_last_wr;

   // Handshake: hold everything while a result waits and the receiver stalls.
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en && (state_ff == ST_RUN);
   assign accept    = req_valid && req_ready;
   assign step      = en && (state_ff != ST_RUN);
   assign at_last   = (col_ff == w_last_ff);

   assign pix_new = '{present: req_present_in, blue: req_blue_in,
                      green: req_green_in, red: req_red_in};

   assign c0 = cells_q[0];
   assign c1 = cells_q[NEXT_IDX];

   // The column leaving cell 0 takes the new pixel into its current row.
   always_comb begin
      c0_mod = c0;
      if (accept) begin
         c0_mod.r2 = pix_new;
      end
   end

   assign cell_ctl.adv    = accept || step;
   assign cell_ctl.vshift = accept && !req_end_of_frame && at_last;

   // Ring of column cells: cell i takes cell i+1, the cell at the row's last
   // column takes cell 0, so the ring length follows the row width.
   for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
      mcb_pkg::col_type src;
      assign src = (COL_W'(i) == w_last_ff) ? c0_mod : cells_q[(i + 1) % MAX_WIDTH];
      mcb_cell u_cell (
         .clock (clock),
         .ctl   (cell_ctl),
         .src   (src),
         .q     (cells_q[i])
      );
   end

   // Select the window for the pixel that enters the pipeline this cycle.
   always_comb begin
      job_valid = 1'b0;
      job_last  = 1'b0;
      center    = c0.r1;
      right_pix = c1.r1;
      up_pix    = c0.r0;
      right_ok  = !at_last;
      up_ok     = rows_ff[1];
      down_ok   = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            job_valid = accept && (rows_ff != 2'd0);
            job_last  = !req_end_of_frame;
            down_ok   = 1'b1;
         end
         ST_FLUSH_PREV: begin
            job_valid = step && (rows_ff != 2'd0);
         end
         ST_FLUSH_CUR: begin
            job_valid = step;
            job_last  = (col_ff == x_end_ff);
            center    = c0.r2;
            right_pix = c1.r2;
            up_pix    = c0.r1;
            right_ok  = (col_ff != x_end_ff);
            up_ok     = (rows_ff != 2'd0);
         end
         default: begin
            job_valid = 1'b0;
         end
      endcase
      left_ok = (col_ff != '0);
   end

   always_comb begin
      nb_pix[0] = left_ff;
      nb_pix[1] = right_pix;
      nb_pix[2] = up_pix;
      nb_pix[3] = pix_new;
      lane_ctl.blend    = center.present && (amount_ff != '0);
      lane_ctl.nb_en[0] = left_ok  && left_ff.present;
      lane_ctl.nb_en[1] = right_ok && right_pix.present;
      lane_ctl.nb_en[2] = up_ok    && up_pix.present;
      lane_ctl.nb_en[3] = down_ok  && pix_new.present;
      for (int k = 0; k < mcb_pkg::NB_N; k++) begin
         nb_red[k]   = nb_pix[k].red;
         nb_green[k] = nb_pix[k].green;
         nb_blue[k]  = nb_pix[k].blue;
      end
   end

   // Effective width of a row width write: zero acts as one, clamp to the ring.
   assign wr_width = {1'b0, csr_wdata[mcb_pkg::ROW_WIDTH_W-1:0]};

   always_comb begin
      if (wr_width == '0) begin
         w_last_wr = '0;
      end else if (wr_width > WW_W'(MAX_WIDTH)) begin
         w_last_wr = COL_W'(MAX_WIDTH - 1);
      end else begin
         w_last_wr = COL_W'(wr_width - WW_W'(1));
      end
   end

   // Next state of the sequencer.
   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      rows_in   = rows_ff;
      x_end_in  = x_end_ff;
      amount_in = amount_ff;
      w_last_in = w_last_ff;
      left_in   = left_ff;
      if (accept || step) begin
         left_in = center;
      end
      unique case (state_ff)
         ST_RUN: begin
            if (accept) begin
               if (req_end_of_frame) begin
                  x_end_in = col_ff;
                  if (at_last) begin
                     state_in = ST_FLUSH_CUR;
                     col_in   = '0;
                  end else begin
                     state_in = ST_FLUSH_PREV;
                     col_in   = COL_W'(col_ff + 1'b1);
                  end
               end else if (at_last) begin
                  col_in = '0;
                  if (!rows_ff[1]) begin
                     rows_in = rows_ff + 2'd1;
                  end
               end else begin
                  col_in = COL_W'(col_ff + 1'b1);
               end
            end
         end
         ST_FLUSH_PREV: begin
            if (step) begin
               if (at_last) begin
                  state_in = ST_FLUSH_CUR;
                  col_in   = '0;
               end else begin
                  col_in = COL_W'(col_ff + 1'b1);
               end
            end
         end
         ST_FLUSH_CUR: begin
            if (step) begin
               if (col_ff == x_end_ff) begin
                  state_in = ST_RUN;
                  col_in   = '0;
                  rows_in  = 2'd0;
               end else begin
                  col_in = COL_W'(col_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
      if (csr_we) begin
         if (csr_index == mcb_pkg::REG_AMOUNT) begin
            amount_in = csr_wdata[CW-1:0];
         end
         if (csr_index == mcb_pkg::REG_ROW_WIDTH) begin
            w_last_in = w_last_wr;
            col_in    = '0;
            rows_in   = 2'd0;
         end
      end
   end

   // Sequencer state and result valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         col_ff       <= '0;
         rows_ff      <= 2'd0;
         amount_ff    <= mcb_pkg::AMOUNT_RESET;
         w_last_ff    <= W_LAST_RST;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         col_ff    <= col_in;
         rows_ff   <= rows_in;
         amount_ff <= amount_in;
         w_last_ff <= w_last_in;
         if (en) begin
            p_valid_ff   <= job_valid;
            rsp_valid_ff <= p_valid_ff;
         end
      end
   end

   // Payload: advance with the pipeline, no reset.
   always_ff @(posedge clock) begin
      x_end_ff <= x_end_in;
      left_ff  <= left_in;
      if (en) begin
         p_present_ff   <= center.present;
         p_last_ff      <= job_last;
         rsp_present_ff <= p_present_ff;
         rsp_last_ff    <= p_last_ff;
      end
   end

   mcb_lane u_lane_red (
      .clock  (clock),
      .en     (en),
      .amount (amount_ff),
      .ctl    (lane_ctl),
      .center (center.red),
      .nb     (nb_red),
      .result (rsp_red_out)
   );

   mcb_lane u_lane_green (
      .clock  (clock),
      .en     (en),
      .amount (amount_ff),
      .ctl    (lane_ctl),
      .center (center.green),
      .nb     (nb_green),
      .result (rsp_green_out)
   );

   mcb_lane u_lane_blue (
      .clock  (clock),
      .en     (en),
      .amount (amount_ff),
      .ctl    (lane_ctl),
      .center (center.blue),
      .nb     (nb_blue),
      .result (rsp_blue_out)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_present_out = rsp_present_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

// ===== dv/mcb_blur_checker.sv =====
// Checker for the masked cross blur: predicts the blurred pixels of every request
// and compares them with the rsp_ channel. Depends on mcb_pkg.
`timescale 1ns / 1ps

module mcb_blur_checker #(
   parameter int MAX_WIDTH = mcb_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [mcb_pkg::CHAN_W-1:0]     req_red_in,
   input  logic [mcb_pkg::CHAN_W-1:0]     req_green_in,
   input  logic [mcb_pkg::CHAN_W-1:0]     req_blue_in,
   input  logic                           req_present_in,
   input  logic                           req_end_of_frame,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [mcb_pkg::CHAN_W-1:0]     rsp_red_out,
   input  logic [mcb_pkg::CHAN_W-1:0]     rsp_green_out,
   input  logic [mcb_pkg::CHAN_W-1:0]     rsp_blue_out,
   input  logic                           rsp_present_out,
   input  logic                           rsp_last_of_run,
   input  logic                           csr_we,
   input  logic [mcb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mcb_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                    fail_count,
   output int unsigned                    pending_count
);

   import mcb_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              present;
      logic              last;
   } blurred_pixel_type;

   // rows: 0 above, 1 previous row, 2 current row
   pix_type           window_rows [0:2][0:MAX_WIDTH-1];
   int unsigned       next_col;
   int unsigned       full_rows;
   int unsigned       blur_amount;
   int unsigned       row_width_reg;
   blurred_pixel_type expected_pixels [$];

   function automatic blurred_pixel_type blur_pixel(int unsigned row, int unsigned col,
                                                    int unsigned right_max, bit up_ok,
                                                    bit down_ok);
      logic [24:0]             ctr;
      logic [24:0]             nb [4];
      int unsigned             nn;
      int unsigned             acc;
      int unsigned             share;
      logic [2:0][CHAN_W-1:0]  res;
      blurred_pixel_type       px;

      ctr = window_rows[row][col];
      nn  = 0;
      if (col > 0 && window_rows[row][col-1].present) begin
         nb[nn] = window_rows[row][col-1];
         nn++;
      end
      if (col < right_max && window_rows[row][col+1].present) begin
         nb[nn] = window_rows[row][col+1];
         nn++;
      end
      if (up_ok && row > 0 && window_rows[row-1][col].present) begin
         nb[nn] = window_rows[row-1][col];
         nn++;
      end
      if (down_ok && row < 2 && window_rows[row+1][col].present) begin
         nb[nn] = window_rows[row+1][col];
         nn++;
      end
      share = blur_amount >> 2;
      for (int c = 0; c < 3; c++) begin
         res[c] = ctr[8*c +: 8];
         if (ctr[24] && blur_amount != 0) begin
            acc = ctr[8*c +: 8] * (int'(CHAN_MAX) - blur_amount);
            for (int unsigned k = 0; k < nn; k++) acc += nb[k][8*c +: 8] * share;
            acc = acc >> 8;
            // keep a visible channel from going dark
            if (acc == 0 && ctr[8*c +: 8] > FLOOR_LIMIT) acc = 1;
            if (acc > CHAN_MAX) acc = CHAN_MAX;
            res[c] = acc[7:0];
         end
      end
      px.red     = res[0];
      px.green   = res[1];
      px.blue    = res[2];
      px.present = ctr[24];
      px.last    = 1'b0;
      return px;
   endfunction

   task automatic predict_request(pix_type pixel, logic eof);
      int unsigned       w;
      int unsigned       x;
      blurred_pixel_type batch [$];

      w = row_width_reg;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      x = next_col;
      if (x >= w) x = w - 1;
      window_rows[2][x] = pixel;

      if (full_rows >= 1) batch.push_back(blur_pixel(1, x, w - 1, full_rows >= 2, 1'b1));

      if (eof) begin
         // flush the previous row, then the current row up to this column
         if (full_rows >= 1) begin
            for (int unsigned c = x + 1; c < w; c++)
               batch.push_back(blur_pixel(1, c, w - 1, full_rows >= 2, 1'b0));
         end
         for (int unsigned c = 0; c <= x; c++)
            batch.push_back(blur_pixel(2, c, x, full_rows >= 1, 1'b0));
         next_col  = 0;
         full_rows = 0;
      end else if (x + 1 >= w) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            window_rows[0][i] = window_rows[1][i];
            window_rows[1][i] = window_rows[2][i];
         end
         next_col = 0;
         if (full_rows < 2) full_rows++;
      end else begin
         next_col = x + 1;
      end

      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) expected_pixels.push_back(batch[i]);
   endtask

   always @(posedge clock) begin : watch
      blurred_pixel_type got;
      blurred_pixel_type want;

      if (reset) begin
         for (int r = 0; r < 3; r++)
            for (int i = 0; i < MAX_WIDTH; i++) window_rows[r][i] = '0;
         next_col      = 0;
         full_rows     = 0;
         blur_amount   = AMOUNT_RESET;
         row_width_reg = ROW_WIDTH_RESET;
         expected_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_AMOUNT: begin
                  blur_amount = csr_wdata;
               end
               REG_ROW_WIDTH: begin
                  row_width_reg = csr_wdata[ROW_WIDTH_W-1:0];
                  next_col      = 0;
                  full_rows     = 0;
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_request({req_present_in, req_blue_in, req_green_in, req_red_in},
                            req_end_of_frame);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_red_out, rsp_green_out, rsp_blue_out, rsp_present_out,
                   rsp_last_of_run};
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel r=%0d g=%0d b=%0d p=%0b l=%0b", $time,
                        got.red, got.green, got.blue, got.present, got.last);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.present !== want.present ||
                   got.last !== want.last) begin
                  $display("%0t: expected %0d/%0d/%0d p%0b l%0b got %0d/%0d/%0d p%0b l%0b",
                           $time, want.red, want.green, want.blue, want.present,
                           want.last, got.red, got.green, got.blue, got.present,
                           got.last);
                  fail_count++;
               end
            end
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

// ===== dv/masked_cross_blur_2d_tb.sv =====
// Top of the masked cross blur testbench: clock, reset, requests, csr writes and
// receiver stalls around the block, with mcb_blur_checker. Depends on mcb_pkg.
`timescale 1ns / 1ps

module masked_cross_blur_2d_tb;

   import mcb_pkg::*;

   localparam int MAX_WIDTH    = MAX_WIDTH_DEFAULT;
   localparam int RANDOM_ITEMS = 155;
   localparam int IDLE_LIMIT   = 5000;
   // two pipeline stages plus a full flush rotation, with margin
   localparam int DRAIN_CYCLES = MAX_WIDTH + 8;

   // receiver behavior, switched at random by the receiver process
   typedef enum logic [1:0] {
      RDY_FULL,
      RDY_COIN,
      RDY_CADENCE,
      RDY_SPARSE
   } ready_mode_type;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [CHAN_W-1:0]      req_red_in       = '0;
   logic [CHAN_W-1:0]      req_green_in     = '0;
   logic [CHAN_W-1:0]      req_blue_in      = '0;
   logic                   req_present_in   = 1'b0;
   logic                   req_end_of_frame = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [CHAN_W-1:0]      rsp_red_out;
   logic [CHAN_W-1:0]      rsp_green_out;
   logic [CHAN_W-1:0]      rsp_blue_out;
   logic                   rsp_present_out;
   logic                   rsp_last_of_run;
   logic                   csr_we           = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata        = '0;

   int unsigned            fail_count;
   int unsigned            pending_count;
   int unsigned            requests_sent    = 0;
   int unsigned            burst_left       = 0;
   int unsigned            row_width_set    = ROW_WIDTH_RESET;
   int unsigned            idle_cycles      = 0;
   ready_mode_type         ready_mode       = RDY_FULL;
   int unsigned            mode_left        = 0;
   int unsigned            ready_tick       = 0;

   masked_cross_blur_2d #(
      .MAX_WIDTH (MAX_WIDTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_present_in   (req_present_in),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_present_out  (rsp_present_out),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   mcb_blur_checker #(
      .MAX_WIDTH (MAX_WIDTH)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_present_in   (req_present_in),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_present_out  (rsp_present_out),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic pix_type mk_pix(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                      logic [CHAN_W-1:0] b, logic p);
      pix_type px;
      px.red     = r;
      px.green   = g;
      px.blue    = b;
      px.present = p;
      return px;
   endfunction

   // favor the channel extremes and the region around the dark floor
   function automatic logic [CHAN_W-1:0] random_chan();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return CHAN_MAX;
         2:       return $urandom_range(0, 8);
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic pix_type random_pix();
      return mk_pix(random_chan(), random_chan(), random_chan(), $urandom_range(0, 3) != 0);
   endfunction

   // Send one request. Enter and leave on a falling edge. Between bursts may drop
   // valid for a random gap; inside a burst keep valid high back to back.
   task automatic send_pixel(pix_type px, logic eof);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_valid        <= 1'b1;
      req_red_in       <= px.red;
      req_green_in     <= px.green;
      req_blue_in      <= px.blue;
      req_present_in   <= px.present;
      req_end_of_frame <= eof;
      // hold the request until the block takes it
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
      requests_sent++;
   endtask

   // Drain the block before a register write: drop valid, wait for every
   // expected pixel, then give a request without results time to finish.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (idx == REG_ROW_WIDTH) row_width_set = data[ROW_WIDTH_W-1:0];
   endtask

   // Receiver: cycle through full speed, coin flips, a fixed cadence and
   // sparse acceptance so stalls land on every phase of the flush.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(8, 60);
      end
      mode_left--;
      ready_tick++;
      case (ready_mode)
         RDY_FULL:    rsp_ready <= 1'b1;
         RDY_COIN:    rsp_ready <= $urandom_range(0, 1);
         RDY_CADENCE: rsp_ready <= (ready_tick % 4) != 3;
         default:     rsp_ready <= $urandom_range(0, 3) == 0;
      endcase
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: watchdog expired, %0d pixels outstanding", $time, pending_count);
         $display("masked_cross_blur_2d regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned eff_width;
      int unsigned n_rows;
      int unsigned last_len;
      int unsigned kind;
      int unsigned directed_count;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed part ---

      // lone pixel at full blur: no neighbors, so channels above the floor
      // limit come out as 1 and the rest as 0
      write_reg(REG_AMOUNT, CHAN_MAX);
      write_reg(REG_ROW_WIDTH, 1);
      send_pixel(mk_pix(8'd5, 8'd4, 8'd200, 1'b1), 1'b1);

      // width zero behaves as width one; first row stays silent
      settle();
      write_reg(REG_ROW_WIDTH, 0);
      send_pixel(mk_pix(8'd255, 8'd255, 8'd255, 1'b1), 1'b0);
      send_pixel(mk_pix(8'd10, 8'd20, 8'd30, 1'b0), 1'b0);
      send_pixel(mk_pix(8'd1, 8'd2, 8'd3, 1'b1), 1'b1);

      // zero amount passes everything through, absent pixels included
      settle();
      write_reg(REG_AMOUNT, 0);
      write_reg(REG_ROW_WIDTH, 2);
      send_pixel(mk_pix(8'd0, 8'd0, 8'd0, 1'b1), 1'b0);
      send_pixel(mk_pix(8'd255, 8'd255, 8'd255, 1'b1), 1'b0);
      send_pixel(mk_pix(8'd7, 8'd8, 8'd9, 1'b1), 1'b0);
      send_pixel(mk_pix(8'd9, 8'd9, 8'd9, 1'b0), 1'b1);

      // short last row: end of frame in the middle of the second row
      settle();
      write_reg(REG_AMOUNT, 128);
      write_reg(REG_ROW_WIDTH, 3);
      repeat (3) send_pixel(random_pix(), 1'b0);
      send_pixel(random_pix(), 1'b0);
      send_pixel(random_pix(), 1'b1);

      // change the amount in the middle of a frame
      settle();
      write_reg(REG_AMOUNT, 4);
      write_reg(REG_ROW_WIDTH, 2);
      repeat (3) send_pixel(random_pix(), 1'b0);
      settle();
      write_reg(REG_AMOUNT, 200);
      send_pixel(random_pix(), 1'b1);

      // rewriting the row width restarts the frame
      settle();
      write_reg(REG_ROW_WIDTH, 3);
      repeat (4) send_pixel(random_pix(), 1'b0);
      settle();
      write_reg(REG_ROW_WIDTH, 3);
      send_pixel(random_pix(), 1'b0);
      send_pixel(random_pix(), 1'b0);
      send_pixel(random_pix(), 1'b1);

      directed_count = requests_sent;

      // --- random frames ---
      while (requests_sent < directed_count + RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            settle();
            if ($urandom_range(0, 1) == 0) begin
               case ($urandom_range(0, 4))
                  0:       write_reg(REG_AMOUNT, 0);
                  1:       write_reg(REG_AMOUNT, CHAN_MAX);
                  2:       write_reg(REG_AMOUNT, $urandom_range(1, 3));
                  default: write_reg(REG_AMOUNT, $urandom_range(0, 255));
               endcase
            end
            if ($urandom_range(0, 1) == 0) begin
               // mostly narrow rows; wide and out-of-range widths now and then
               case ($urandom_range(0, 9))
                  0:       write_reg(REG_ROW_WIDTH, 0);
                  1:       write_reg(REG_ROW_WIDTH, 1);
                  2:       write_reg(REG_ROW_WIDTH, MAX_WIDTH);
                  3:       write_reg(REG_ROW_WIDTH, 63);
                  4:       write_reg(REG_ROW_WIDTH, $urandom_range(MAX_WIDTH + 1, 62));
                  default: write_reg(REG_ROW_WIDTH, $urandom_range(2, 6));
               endcase
            end
         end

         eff_width = row_width_set;
         if (eff_width == 0) eff_width = 1;
         if (eff_width > MAX_WIDTH) eff_width = MAX_WIDTH;
         n_rows   = (eff_width > 8) ? $urandom_range(1, 2) : $urandom_range(1, 4);
         last_len = $urandom_range(1, eff_width);
         kind     = $urandom_range(0, 7);

         case (kind)
            0: begin
               // whole rows with no end of frame: the stream runs on
               repeat (n_rows * eff_width) send_pixel(random_pix(), 1'b0);
            end
            1: begin
               // broken frame: stop mid-row and restart with a width write
               repeat ((n_rows - 1) * eff_width + last_len) send_pixel(random_pix(), 1'b0);
               settle();
               write_reg(REG_ROW_WIDTH, row_width_set);
            end
            default: begin
               repeat ((n_rows - 1) * eff_width + last_len - 1)
                  send_pixel(random_pix(), 1'b0);
               send_pixel(random_pix(), 1'b1);
            end
         endcase
      end

      // --- drain and verdict ---
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("masked_cross_blur_2d regression: pass");
      end else begin
         if (pending_count != 0) $display("%0d pixels never arrived", pending_count);
         $display("masked_cross_blur_2d regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/mcb_pkg.sv
hdl/mcb_cell.sv
hdl/mcb_lane.sv
hdl/masked_cross_blur_2d.sv
dv/mcb_blur_checker.sv
dv/masked_cross_blur_2d_tb.sv
